// ===== design/binomial_lattice_option_pricer_defines.svh =====
// Assertion macros shared by the option pricer RTL.
`ifndef BINOMIAL_LATTICE_OPTION_PRICER_DEFINES_SVH
`define BINOMIAL_LATTICE_OPTION_PRICER_DEFINES_SVH
`ifndef SYNTHESIS
`define BLOP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("blop assertion failed");
`define BLOP_ASSERT_IMP(lbl, ante, cons) \
    `BLOP_ASSERT(lbl, (ante) |-> (cons))
`else
`define BLOP_ASSERT(lbl, prop)
`define BLOP_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ===== design/blop_pkg.sv =====
// Types, constants and the helper function of the binomial lattice option pricer.
package blop_pkg;

    localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
    localparam logic [10:0] STEPS_RESET = 11'd64;

    typedef struct packed {
        logic [31:0] spot;
        logic [31:0] strike;
        logic [31:0] up_factor;
        logic [30:0] down_factor;
        logic [31:0] up_prob;
        logic [31:0] discount_factor;
        logic        is_put;
        logic        early_exercise;
    } item_t;

    typedef struct packed {
        logic [31:0] option_value;
        logic        overflow;
    } result_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] price;
        logic [31:0] value;
        logic        ovf;
    } node_t;

    typedef struct packed {
        logic        start;
        logic [31:0] p;
        logic [31:0] q;
        logic [30:0] d;
        logic [31:0] disc;
        logic [31:0] strike;
        logic        put;
        logic        amer;
    } cell_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CTR_EVEN,
        ST_CTR_A,
        ST_CTR_B,
        ST_CTR_C,
        ST_UP_A,
        ST_UP_B,
        ST_UP_C,
        ST_DN_SETUP,
        ST_DN_A,
        ST_DN_B,
        ST_DN_C,
        ST_PASS_INIT,
        ST_PASS_RUN,
        ST_FINISH
    } state_t;

    function automatic logic [31:0] payoff(input logic [31:0] price,
                                           input logic [31:0] strike,
                                           input logic put);
        logic [31:0] r;
        if (put)
            r = (strike > price) ? strike - price : 32'd0;
        else
            r = (price > strike) ? price - strike : 32'd0;
        return r;
    endfunction

endpackage

// ===== design/blop_cell.sv =====
// One backward-induction cell: folds two neighbor nodes into one node of the previous step.
module blop_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  blop_pkg::cell_ctl_t  ctl,
    input  logic                 active,
    input  blop_pkg::node_t      feed,
    output blop_pkg::node_t      pass
);
    import blop_pkg::*;

    logic [31:0] prev_price_reg;
    logic [31:0] prev_value_reg;
    logic        prev_ovf_reg;
    logic        have_prev_reg;

    logic        s1_valid_reg;
    logic        s1_byp_reg;
    logic [63:0] s1_prod_p_reg;
    logic [63:0] s1_prod_q_reg;
    logic [62:0] s1_prod_d_reg;
    logic [31:0] s1_price_reg;
    logic [31:0] s1_value_reg;
    logic        s1_ovf_reg;

    logic        s2_valid_reg;
    logic        s2_byp_reg;
    logic [31:0] s2_cont_reg;
    logic [31:0] s2_price_reg;
    logic [31:0] s2_value_reg;
    logic        s2_ovf_reg;

    logic        s3_valid_reg;
    logic        s3_byp_reg;
    logic [63:0] s3_prod_reg;
    logic [31:0] s3_price_reg;
    logic [31:0] s3_value_reg;
    logic        s3_ovf_reg;

    logic        s4_valid_reg;
    logic [31:0] s4_price_reg;
    logic [31:0] s4_value_reg;
    logic        s4_ovf_reg;

    logic [63:0] acc;
    logic [31:0] cont_v;
    logic [31:0] price_v;
    logic        price_ovf;
    logic [31:0] disc_v;
    logic        disc_ovf;
    logic [31:0] exer_v;
    logic [31:0] final_v;

    always_comb
    begin
        acc       = s1_prod_p_reg + s1_prod_q_reg;
        cont_v    = acc[62:31];
        price_ovf = s1_prod_d_reg[62];
        price_v   = price_ovf ? 32'hFFFF_FFFF : s1_prod_d_reg[61:30];
        disc_ovf  = s3_prod_reg[63];
        disc_v    = disc_ovf ? 32'hFFFF_FFFF : s3_prod_reg[62:31];
        exer_v    = payoff(s3_price_reg, ctl.strike, ctl.put);
        final_v   = (ctl.amer && (exer_v > disc_v)) ? exer_v : disc_v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.start)
                have_prev_reg <= 1'b0;
            else if (feed.valid)
                have_prev_reg <= 1'b1;
            s1_valid_reg <= feed.valid && !ctl.start && (!active || have_prev_reg);
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (feed.valid)
        begin
            prev_price_reg <= feed.price;
            prev_value_reg <= feed.value;
            prev_ovf_reg   <= feed.ovf;
        end
        s1_byp_reg    <= !active;
        s1_prod_p_reg <= ctl.p * prev_value_reg;
        s1_prod_q_reg <= ctl.q * feed.value;
        s1_prod_d_reg <= prev_price_reg * ctl.d;
        s1_price_reg  <= feed.price;
        s1_value_reg  <= feed.value;
        s1_ovf_reg    <= feed.ovf || (active && prev_ovf_reg);

        s2_byp_reg    <= s1_byp_reg;
        s2_cont_reg   <= cont_v;
        s2_price_reg  <= s1_byp_reg ? s1_price_reg : price_v;
        s2_value_reg  <= s1_value_reg;
        s2_ovf_reg    <= s1_ovf_reg || (!s1_byp_reg && price_ovf);

        s3_byp_reg    <= s2_byp_reg;
        s3_prod_reg   <= ctl.disc * s2_cont_reg;
        s3_price_reg  <= s2_price_reg;
        s3_value_reg  <= s2_value_reg;
        s3_ovf_reg    <= s2_ovf_reg;

        s4_price_reg  <= s3_price_reg;
        s4_value_reg  <= s3_byp_reg ? s3_value_reg : final_v;
        s4_ovf_reg    <= s3_ovf_reg || (!s3_byp_reg && disc_ovf);
    end

    assign pass.valid = s4_valid_reg;
    assign pass.price = s4_price_reg;
    assign pass.value = s4_value_reg;
    assign pass.ovf   = s4_ovf_reg;

endmodule

// ===== design/binomial_lattice_option_pricer.sv =====
// Top level of the binomial lattice option pricer: leaf builder, node memory and cell chain.
//
// Input channel item_valid/item_stall/item carries one option per transaction; the
// result channel result_valid/result_stall/result returns its root value and an
// overflow flag. The step count N comes from the APB register, whose address is not
// decoded. An option is taken only while the block is idle. Leaf prices are built
// outward from the centre leaf by one shared multiplier. Backward induction then
// streams the node memory through its single read port and a chain of CELLS cells;
// each pass retires up to CELLS steps. The result sits in an output register; a
// stalled receiver does not stop the next option from being taken, but a second
// result waits until the first transaction completes. Reset sets the step count to
// 64, drops any work in progress and empties the output register.
`include "binomial_lattice_option_pricer_defines.svh"
module binomial_lattice_option_pricer #(
    parameter int MAX_STEPS = 1024,
    parameter int CELLS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [1:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              item_valid,
    output logic              item_stall,
    input  blop_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output blop_pkg::result_t result
);
    import blop_pkg::*;

    localparam int NW = $clog2(MAX_STEPS + 1);
    localparam int CW = $clog2(CELLS + 1);

    state_t           state_reg;
    state_t           state_next;
    logic [10:0]      steps_reg;
    item_t            job_reg;
    logic [31:0]      p_reg;
    logic [NW-1:0]    n_reg;
    logic [NW-1:0]    idx_reg;
    logic [31:0]      cur_reg;
    logic [31:0]      dn_start_reg;
    logic [63:0]      mres_reg;
    logic             ovf_reg;
    logic [NW-1:0]    rem_reg;
    logic [CW-1:0]    act_reg;
    logic [NW:0]      rd_cnt_reg;
    logic [NW:0]      wr_cnt_reg;
    logic             rd_valid_reg;
    logic [63:0]      rdata_reg;
    logic [31:0]      final_reg;
    result_t          out_reg;
    logic             out_valid_reg;
    logic [63:0]      mem [0:MAX_STEPS];

    logic             accept;
    logic             cfg_write;
    logic [NW-1:0]    n_new;
    logic [NW-1:0]    lo;
    logic [31:0]      mul_a;
    logic [31:0]      mul_b;
    logic             msat;
    logic [31:0]      mval;
    logic             we;
    logic [NW-1:0]    waddr;
    logic [31:0]      wprice;
    logic [31:0]      wvalue;
    logic             rd_issue;
    logic [CW-1:0]    act_new;
    logic             last_wr;
    logic             pass_done;
    logic             out_free;
    cell_ctl_t        ctl;
    node_t            link [0:CELLS];
    logic [CELLS-1:0] active;

    assign accept    = item_valid && !item_stall;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = {21'd0, steps_reg};
    assign lo        = n_reg >> 1;
    assign msat      = mres_reg[63:62] != 2'd0;
    assign mval      = msat ? 32'hFFFF_FFFF : mres_reg[61:30];
    assign rd_issue  = (state_reg == ST_PASS_RUN) && (rd_cnt_reg <= {1'b0, rem_reg});
    assign last_wr   = link[CELLS].valid &&
                       (wr_cnt_reg == ({1'b0, rem_reg} - (NW+1)'(act_reg)));
    assign pass_done = last_wr && (rem_reg == NW'(act_reg));
    assign out_free  = !out_valid_reg || !result_stall;

    always_comb
    begin
        if (steps_reg == 11'd0)
            n_new = NW'(1);
        else if (32'(steps_reg) > MAX_STEPS)
            n_new = NW'(MAX_STEPS);
        else
            n_new = NW'(steps_reg);
        if (32'(rem_reg) >= CELLS)
            act_new = CW'(CELLS);
        else
            act_new = CW'(rem_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = n_new[0] ? ST_CTR_A : ST_CTR_EVEN;
            ST_CTR_EVEN: state_next = ST_UP_A;
            ST_CTR_A:    state_next = ST_CTR_B;
            ST_CTR_B:    state_next = ST_CTR_C;
            ST_CTR_C:    state_next = ST_UP_A;
            ST_UP_A:     state_next = (idx_reg == '0) ? ST_DN_SETUP : ST_UP_B;
            ST_UP_B:     state_next = ST_UP_C;
            ST_UP_C:     state_next = ST_UP_A;
            ST_DN_SETUP: state_next = ST_DN_A;
            ST_DN_A:     state_next = (idx_reg == n_reg) ? ST_PASS_INIT : ST_DN_B;
            ST_DN_B:     state_next = ST_DN_C;
            ST_DN_C:     state_next = ST_DN_A;
            ST_PASS_INIT: state_next = ST_PASS_RUN;
            ST_PASS_RUN:
                if (pass_done)
                    state_next = out_free ? ST_IDLE : ST_FINISH;
                else if (last_wr)
                    state_next = ST_PASS_INIT;
            ST_FINISH:
                if (out_free)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        mul_a  = cur_reg;
        mul_b  = job_reg.up_factor;
        we     = 1'b0;
        waddr  = idx_reg;
        wprice = mval;
        case (state_reg)
            ST_CTR_EVEN:
            begin
                we     = 1'b1;
                waddr  = lo;
                wprice = job_reg.spot;
            end
            ST_CTR_A:
                mul_a = job_reg.spot;
            ST_CTR_B:
            begin
                mul_a = job_reg.spot;
                mul_b = {1'b0, job_reg.down_factor};
                we    = 1'b1;
                waddr = lo;
            end
            ST_CTR_C:
            begin
                we    = 1'b1;
                waddr = lo + NW'(1);
            end
            ST_UP_B:
                mul_a = mval;
            ST_UP_C:
            begin
                we    = 1'b1;
                waddr = idx_reg - NW'(1);
            end
            ST_DN_A:
                mul_b = {1'b0, job_reg.down_factor};
            ST_DN_B:
            begin
                mul_a = mval;
                mul_b = {1'b0, job_reg.down_factor};
            end
            ST_DN_C:
            begin
                we    = 1'b1;
                waddr = idx_reg + NW'(1);
            end
            ST_PASS_RUN:
            begin
                we     = link[CELLS].valid;
                waddr  = wr_cnt_reg[NW-1:0];
                wprice = link[CELLS].price;
            end
            default:
                we = 1'b0;
        endcase
        if (state_reg == ST_PASS_RUN)
            wvalue = link[CELLS].value;
        else
            wvalue = payoff(wprice, job_reg.strike, job_reg.is_put);
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= {wprice, wvalue};
        rdata_reg <= mem[rd_cnt_reg[NW-1:0]];
        mres_reg  <= mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            steps_reg     <= STEPS_RESET;
            out_valid_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_issue;
            if (cfg_write)
                steps_reg <= pwdata[10:0];
            if ((state_reg == ST_PASS_RUN && pass_done && out_free) ||
                (state_reg == ST_FINISH && out_free))
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    job_reg <= item;
                    p_reg   <= (item.up_prob > ONE_Q31) ? ONE_Q31 : item.up_prob;
                    n_reg   <= n_new;
                    ovf_reg <= 1'b0;
                end
            ST_CTR_EVEN:
            begin
                cur_reg      <= job_reg.spot;
                dn_start_reg <= job_reg.spot;
                idx_reg      <= lo;
            end
            ST_CTR_B:
            begin
                cur_reg <= mval;
                ovf_reg <= ovf_reg || msat;
            end
            ST_CTR_C:
            begin
                dn_start_reg <= mval;
                idx_reg      <= lo;
                ovf_reg      <= ovf_reg || msat;
            end
            ST_UP_B:
                ovf_reg <= ovf_reg || msat;
            ST_UP_C:
            begin
                cur_reg <= mval;
                idx_reg <= idx_reg - NW'(1);
                ovf_reg <= ovf_reg || msat;
            end
            ST_DN_SETUP:
            begin
                cur_reg <= dn_start_reg;
                idx_reg <= n_reg[0] ? lo + NW'(1) : lo;
            end
            ST_DN_A:
                rem_reg <= n_reg;
            ST_DN_B:
                ovf_reg <= ovf_reg || msat;
            ST_DN_C:
            begin
                cur_reg <= mval;
                idx_reg <= idx_reg + NW'(1);
                ovf_reg <= ovf_reg || msat;
            end
            ST_PASS_INIT:
            begin
                act_reg    <= act_new;
                rd_cnt_reg <= '0;
                wr_cnt_reg <= '0;
            end
            ST_PASS_RUN:
            begin
                if (rd_issue)
                    rd_cnt_reg <= rd_cnt_reg + (NW+1)'(1);
                if (link[CELLS].valid)
                begin
                    wr_cnt_reg <= wr_cnt_reg + (NW+1)'(1);
                    ovf_reg    <= ovf_reg || link[CELLS].ovf;
                end
                if (last_wr)
                    rem_reg <= rem_reg - NW'(act_reg);
                if (pass_done)
                    final_reg <= link[CELLS].value;
                if (pass_done && out_free)
                begin
                    out_reg.option_value <= link[CELLS].value;
                    out_reg.overflow     <= ovf_reg || link[CELLS].ovf;
                end
            end
            ST_FINISH:
                if (out_free)
                begin
                    out_reg.option_value <= final_reg;
                    out_reg.overflow     <= ovf_reg;
                end
            default:
                cur_reg <= cur_reg;
        endcase
    end

    assign item_stall   = state_reg != ST_IDLE;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign ctl.start  = state_reg == ST_PASS_INIT;
    assign ctl.p      = p_reg;
    assign ctl.q      = ONE_Q31 - p_reg;
    assign ctl.d      = job_reg.down_factor;
    assign ctl.disc   = job_reg.discount_factor;
    assign ctl.strike = job_reg.strike;
    assign ctl.put    = job_reg.is_put;
    assign ctl.amer   = job_reg.early_exercise;

    assign link[0].valid = rd_valid_reg && (state_reg == ST_PASS_RUN);
    assign link[0].price = rdata_reg[63:32];
    assign link[0].value = rdata_reg[31:0];
    assign link[0].ovf   = 1'b0;

    for (genvar k = 0; k < CELLS; k++)
    begin : g_cell
        assign active[k] = CW'(k) < act_reg;
        blop_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (ctl),
            .active (active[k]),
            .feed   (link[k]),
            .pass   (link[k+1])
        );
    end

    `BLOP_ASSERT_IMP(a_wr_behind_rd, state_reg == ST_PASS_RUN, wr_cnt_reg <= rd_cnt_reg)
    `BLOP_ASSERT_IMP(a_chain_quiet, state_reg != ST_PASS_RUN, !link[CELLS].valid)
    `BLOP_ASSERT(a_accept_busy, accept |=> (state_reg != ST_IDLE))

endmodule
